// ===== hdl/eamgk_pkg.sv =====
// ----------------------------------------------------------------------------
// eamgk_pkg
// Shared types, codes and the exponential lookup table for the EAM Gaussian
// kernel force engine.
// ----------------------------------------------------------------------------
package eamgk_pkg;

  localparam int FRAC      = 16;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = 8;
  localparam int ACC_W     = 80;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PAIR   = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_FORCE  = 2'd0,
    KIND_ENERGY = 2'd1,
    KIND_VIRIAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_CENTER = 2'd0,
    CFG_INV_W2 = 2'd1,
    CFG_PREF   = 2'd2
  } cfg_idx_e;

  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

  typedef logic [32:0] exp_tbl_t [0:EXP_DEPTH];

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], num[bi]};
      if (rem >= den) begin
        rem    = rem - den;
        q[bi]  = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16 i / depth) in Q32, stepped by a truncated Taylor factor
  function automatic exp_tbl_t build_exp_table();
    exp_tbl_t    tbl;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prev;
    h    = 64'd1 << (36 - EXP_IDX_W);
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * h) >> 32, 64'(n));
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    prev   = 64'd1 << 32;
    tbl[0] = prev[32:0];
    for (int i = 1; i <= EXP_DEPTH; i++) begin
      prev   = (prev * sum + 64'h8000_0000) >> 32;
      tbl[i] = prev[32:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TABLE = build_exp_table();

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // saturate a 49-bit signed value into 48 bits
  function automatic logic [47:0] sat48(input logic [48:0] x);
    if (x[48] != x[47]) return x[48] ? MIN48 : MAX48;
    return x[47:0];
  endfunction

  // magnitude limit for a signed 48-bit result of given sign
  function automatic logic [47:0] satmag48(input logic [63:0] m, input logic neg);
    if (neg) return (m > 64'h8000_0000_0000) ? MIN48 : m[47:0];
    return (m > 64'(MAX48)) ? MAX48 : m[47:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
    if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

endpackage

// ===== hdl/eam_gaussian_kernel_forces_core.sv =====
// Start item: no result. Finish item: energy then three virial rows, each row
// held until taken. Pair item: one force result (zero for a zero-length
// separation, which skips the root and divides), computed on the shared 32x32
// multiplier and the bit-serial square root (32 steps) and divides (17 steps).
// One item at a time; in_ready_o is high only while idle.
// rst_ni clears registers to defaults and all sums and centre state to zero.
// ----------------------------------------------------------------------------
// eam_gaussian_kernel_forces_core
// Embedded-atom Gaussian density kernel: energy, pair forces and virial
// over a streamed neighbour list, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module eam_gaussian_kernel_forces_core import eamgk_pkg::*; #(
  parameter int ATOM_INDEX_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        atom_number_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] shift_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [15:0]        centre_number_o,
  output logic [15:0]        partner_number_o,
  output logic [1:0]         row_select_o,
  output logic signed [47:0] comp_x_o,
  output logic signed [47:0] comp_y_o,
  output logic signed [47:0] comp_z_o,
  output logic               last_of_run_o
);

  localparam int IdW = (ATOM_INDEX_BITS < 16) ? ATOM_INDEX_BITS : 16;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQ, S_A_LO, S_A_HI, S_TLO, S_THI, S_INTERP, S_VAL,
    S_ENERGY, S_M_LO, S_M_HI, S_SLOPE, S_R, S_RSQ, S_G, S_CHK, S_SQRT,
    S_DIV, S_F_LO, S_F_HI, S_F_SAT, S_V_LO, S_V_HI, S_V_ADD, S_FORCE_OUT,
    S_FIN_E, S_FIN_ROW, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0] cent_q;
  logic [30:0] inv_q;
  logic [30:0] pref_q;

  // architectural state
  logic [47:0]    energy_q;
  logic [31:0]    slope_q;
  logic [IdW-1:0] cid_q;
  logic [31:0]    cpos_q [3];
  logic [47:0]    vir_q  [9];

  // latched request
  logic [31:0]    smp_q;
  logic [IdW-1:0] nbr_q;
  logic [31:0]    pos_q [3];
  logic [31:0]    shf_q [3];

  // start datapath
  logic [31:0] dm_q;
  logic        slope_neg_q;
  logic [15:0] s_hi_q;
  logic        azero_q;
  logic [7:0]  a_idx_q;
  logic [11:0] a_frac_q;
  logic [32:0] lo_q;
  logic [31:0] diff_q;
  logic        e32_q;
  logic [30:0] val_q;
  logic [14:0] t_hi_q;

  // pair datapath
  logic [31:0] r_q [3];
  logic [63:0] sumsq_q;
  logic [46:0] gm_q;
  logic        gneg_q;
  logic [63:0] rad_q;
  logic [35:0] srem_q;
  logic [31:0] root_q;
  logic [31:0] drem_q;
  logic [16:0] quo_q;
  logic [47:0] fmag_q [3];
  logic        fneg_q [3];
  logic [4:0]  cnt_q;
  logic [1:0]  k_q;
  logic [1:0]  i_q;
  logic [1:0]  j_q;
  logic [3:0]  vidx_q;

  // shared multiplier / accumulator
  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] acc_d;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic             mul_en;
  logic             mul_hi;
  logic             mul_acc;

  // output register
  logic        out_valid_q;
  kind_e       kind_q;
  logic [15:0] ocid_q;
  logic [15:0] onbr_q;
  logic [1:0]  orow_q;
  logic [47:0] ocomp_q [3];
  logic        olast_q;
  logic        fin_more_q;

  // combinational helpers
  logic [31:0] rmag_k;
  logic [31:0] rmag_n;
  logic [31:0] rmag_i;
  logic [32:0] d_w;
  logic [32:0] dmag_w;
  logic [32:0] e_w;
  logic [30:0] val_w;
  logic [33:0] rsum_w;
  logic [31:0] rcl_w;
  logic [35:0] ssh_w;
  logic [35:0] strial_w;
  logic [32:0] dsh_w;
  logic [63:0] hi_w;
  logic        fneg_w;
  logic [47:0] vmag_w;
  logic        vneg_w;
  logic [47:0] vval_w;
  logic [1:0]  kn_w;

  assign rmag_k = mag32(r_q[k_q]);
  assign rmag_n = mag32(r_q[kn_w]);
  assign rmag_i = mag32(r_q[i_q]);
  assign kn_w   = k_q + 2'd1;

  always_comb begin
    mul_en  = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    mul_hi  = 1'b0;
    mul_acc = 1'b0;
    case (state_q)
      S_SQ: begin
        mul_a = dm_q;
        mul_b = dm_q;
      end
      S_A_LO: begin
        mul_a = acc_q[47:16];
        mul_b = {1'b0, inv_q};
      end
      S_A_HI: begin
        mul_a   = {16'd0, s_hi_q};
        mul_b   = {1'b0, inv_q};
        mul_hi  = 1'b1;
        mul_acc = 1'b1;
      end
      S_INTERP: begin
        mul_a = diff_q;
        mul_b = {12'd0, a_frac_q, 8'd0};
      end
      S_VAL: begin
        mul_a = e_w[31:0];
        mul_b = {1'b0, pref_q};
      end
      S_ENERGY: begin
        mul_a = dm_q;
        mul_b = {1'b0, inv_q};
      end
      S_M_LO: begin
        mul_a = acc_q[47:16];
        mul_b = {1'b0, val_q};
      end
      S_M_HI: begin
        mul_a   = {17'd0, t_hi_q};
        mul_b   = {1'b0, val_q};
        mul_hi  = 1'b1;
        mul_acc = 1'b1;
      end
      S_RSQ: begin
        mul_a   = rmag_k;
        mul_b   = rmag_k;
        mul_acc = (k_q != 2'd0);
      end
      S_G: begin
        mul_a = mag32(smp_q);
        mul_b = mag32(slope_q);
      end
      S_F_LO: begin
        mul_a = {15'd0, quo_q};
        mul_b = gm_q[31:0];
      end
      S_F_HI: begin
        mul_a   = {15'd0, quo_q};
        mul_b   = {17'd0, gm_q[46:32]};
        mul_hi  = 1'b1;
        mul_acc = 1'b1;
      end
      S_V_LO: begin
        mul_a = fmag_q[j_q][31:0];
        mul_b = rmag_i;
      end
      S_V_HI: begin
        mul_a   = {16'd0, fmag_q[j_q][47:32]};
        mul_b   = rmag_i;
        mul_hi  = 1'b1;
        mul_acc = 1'b1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign hi_w  = prod;
  assign acc_d = (mul_acc ? acc_q : '0) +
                 (mul_hi ? ACC_W'({hi_w, 32'd0}) : ACC_W'(prod));

  // start path helpers
  assign d_w    = {smp_q[31], smp_q} - {cent_q[31], cent_q};
  assign dmag_w = d_w[32] ? (~d_w + 33'd1) : d_w;
  assign e_w    = lo_q - {1'b0, acc_q[51:20]};
  assign val_w  = azero_q ? 31'd0 : (e32_q ? pref_q : acc_q[62:32]);

  // separation component with 32-bit clamp
  assign rsum_w = {{2{pos_q[k_q][31]}}, pos_q[k_q]} + {{2{shf_q[k_q][31]}}, shf_q[k_q]}
                - {{2{cpos_q[k_q][31]}}, cpos_q[k_q]};
  assign rcl_w  = (rsum_w[33:31] == 3'b000 || rsum_w[33:31] == 3'b111) ? rsum_w[31:0] :
                  (rsum_w[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // root and divide steps
  assign ssh_w    = {srem_q[33:0], rad_q[63:62]};
  assign strial_w = {2'b00, root_q, 2'b01};
  assign dsh_w    = {drem_q, (cnt_q == 5'd0) ? rmag_k[0] : 1'b0};

  assign fneg_w = r_q[k_q][31] ^ gneg_q;
  assign vneg_w = fneg_q[j_q] ^ r_q[i_q][31];
  assign vmag_w = satmag48(acc_q[79:16], vneg_w);
  assign vval_w = vneg_w ? (~vmag_w + 48'd1) : vmag_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cent_q      <= '0;
      inv_q       <= 31'(1 << FRAC);
      pref_q      <= 31'(1 << FRAC);
      energy_q    <= '0;
      slope_q     <= '0;
      cid_q       <= '0;
      smp_q       <= '0;
      nbr_q       <= '0;
      dm_q        <= '0;
      slope_neg_q <= 1'b0;
      s_hi_q      <= '0;
      azero_q     <= 1'b0;
      a_idx_q     <= '0;
      a_frac_q    <= '0;
      lo_q        <= '0;
      diff_q      <= '0;
      e32_q       <= 1'b0;
      val_q       <= '0;
      t_hi_q      <= '0;
      sumsq_q     <= '0;
      gm_q        <= '0;
      gneg_q      <= 1'b0;
      rad_q       <= '0;
      srem_q      <= '0;
      root_q      <= '0;
      drem_q      <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      vidx_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_FORCE;
      ocid_q      <= '0;
      onbr_q      <= '0;
      orow_q      <= '0;
      olast_q     <= 1'b0;
      fin_more_q  <= 1'b0;
      for (int n = 0; n < 3; n++) begin
        cpos_q[n]  <= '0;
        pos_q[n]   <= '0;
        shf_q[n]   <= '0;
        r_q[n]     <= '0;
        fmag_q[n]  <= '0;
        fneg_q[n]  <= 1'b0;
        ocomp_q[n] <= '0;
      end
      for (int n = 0; n < 9; n++) vir_q[n] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CENTER: cent_q <= cfg_data_i;
          CFG_INV_W2: inv_q  <= cfg_data_i[30:0];
          CFG_PREF:   pref_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      if (mul_en) acc_q <= acc_d;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              OP_START: begin
                smp_q     <= sample_value_i;
                cid_q     <= atom_number_i[IdW-1:0];
                cpos_q[0] <= pos_x_i;
                cpos_q[1] <= pos_y_i;
                cpos_q[2] <= pos_z_i;
                state_q   <= S_DIFF;
              end
              OP_PAIR: begin
                smp_q    <= sample_value_i;
                nbr_q    <= atom_number_i[IdW-1:0];
                pos_q[0] <= pos_x_i;
                pos_q[1] <= pos_y_i;
                pos_q[2] <= pos_z_i;
                shf_q[0] <= shift_x_i;
                shf_q[1] <= shift_y_i;
                shf_q[2] <= shift_z_i;
                k_q      <= '0;
                state_q  <= S_R;
              end
              OP_FINISH: state_q <= S_FIN_E;
              default: ;
            endcase
          end
        end

        // ---- centre atom ----
        S_DIFF: begin
          dm_q        <= dmag_w[32] ? 32'hFFFF_FFFF : dmag_w[31:0];
          slope_neg_q <= !d_w[32] && (d_w != 33'd0);
          state_q     <= S_SQ;
        end
        S_SQ:   state_q <= S_A_LO;
        S_A_LO: begin
          s_hi_q  <= acc_q[63:48];
          state_q <= S_A_HI;
        end
        S_A_HI: state_q <= S_TLO;
        S_TLO: begin
          // exponent argument a = product >> 17; past the table span means zero
          azero_q  <= |acc_q[79:37];
          a_idx_q  <= acc_q[36:29];
          a_frac_q <= acc_q[28:17];
          lo_q     <= EXP_TABLE[{1'b0, acc_q[36:29]}];
          state_q  <= S_THI;
        end
        S_THI: begin
          diff_q  <= 32'(lo_q - EXP_TABLE[{1'b0, a_idx_q} + 9'd1]);
          state_q <= S_INTERP;
        end
        S_INTERP: state_q <= S_VAL;
        S_VAL: begin
          e32_q   <= e_w[32];
          state_q <= S_ENERGY;
        end
        S_ENERGY: begin
          val_q    <= val_w;
          energy_q <= sat48({energy_q[47], energy_q} + 49'(val_w));
          state_q  <= S_M_LO;
        end
        S_M_LO: begin
          t_hi_q  <= acc_q[62:48];
          state_q <= S_M_HI;
        end
        S_M_HI: state_q <= S_SLOPE;
        S_SLOPE: begin
          slope_q <= (acc_q[79:16] == 64'd0) ? 32'd0 : sat32(acc_q[79:16], slope_neg_q);
          state_q <= S_IDLE;
        end

        // ---- neighbour pair ----
        S_R: begin
          r_q[k_q] <= rcl_w;
          k_q      <= (k_q == 2'd2) ? 2'd0 : kn_w;
          if (k_q == 2'd2) state_q <= S_RSQ;
        end
        S_RSQ: begin
          k_q <= (k_q == 2'd2) ? 2'd0 : kn_w;
          if (k_q == 2'd2) state_q <= S_G;
        end
        S_G: begin
          sumsq_q <= acc_q[63:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          gm_q   <= acc_q[62:16];
          gneg_q <= smp_q[31] ^ slope_q[31];
          if (sumsq_q == 64'd0) begin
            for (int n = 0; n < 3; n++) begin
              fmag_q[n] <= '0;
              fneg_q[n] <= 1'b0;
            end
            state_q <= S_FORCE_OUT;
          end else begin
            rad_q   <= sumsq_q;
            srem_q  <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ssh_w >= strial_w) begin
            srem_q <= ssh_w - strial_w;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            srem_q <= ssh_w;
            root_q <= {root_q[30:0], 1'b0};
          end
          rad_q <= {rad_q[61:0], 2'b00};
          cnt_q <= (cnt_q == 5'd31) ? 5'd0 : cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            // quotient fits 17 bits, so the upper dividend bits preload the remainder
            k_q     <= '0;
            drem_q  <= {1'b0, rmag_k[31:1]};
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dsh_w >= {1'b0, root_q}) begin
            drem_q <= 32'(dsh_w - {1'b0, root_q});
            quo_q  <= {quo_q[15:0], 1'b1};
          end else begin
            drem_q <= dsh_w[31:0];
            quo_q  <= {quo_q[15:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) state_q <= S_F_LO;
        end
        S_F_LO: state_q <= S_F_HI;
        S_F_HI: state_q <= S_F_SAT;
        S_F_SAT: begin
          fmag_q[k_q] <= satmag48(acc_q[79:16], fneg_w);
          fneg_q[k_q] <= fneg_w && (acc_q[79:16] != 64'd0);
          if (k_q == 2'd2) begin
            i_q     <= '0;
            j_q     <= '0;
            vidx_q  <= '0;
            state_q <= S_V_LO;
          end else begin
            k_q     <= kn_w;
            drem_q  <= {1'b0, rmag_n[31:1]};
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_V_LO: state_q <= S_V_HI;
        S_V_HI: state_q <= S_V_ADD;
        S_V_ADD: begin
          vir_q[vidx_q] <= sat48({vir_q[vidx_q][47], vir_q[vidx_q]} - {vval_w[47], vval_w});
          vidx_q        <= vidx_q + 4'd1;
          if (j_q == 2'd2) begin
            j_q <= '0;
            i_q <= i_q + 2'd1;
          end else begin
            j_q <= j_q + 2'd1;
          end
          state_q <= (vidx_q == 4'd8) ? S_FORCE_OUT : S_V_LO;
        end
        S_FORCE_OUT: begin
          kind_q      <= KIND_FORCE;
          ocid_q      <= 16'(cid_q);
          onbr_q      <= 16'(nbr_q);
          orow_q      <= '0;
          olast_q     <= 1'b0;
          for (int n = 0; n < 3; n++)
            ocomp_q[n] <= fneg_q[n] ? (~fmag_q[n] + 48'd1) : fmag_q[n];
          fin_more_q  <= 1'b0;
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end

        // ---- finish ----
        S_FIN_E: begin
          kind_q      <= KIND_ENERGY;
          ocid_q      <= '0;
          onbr_q      <= '0;
          orow_q      <= '0;
          olast_q     <= 1'b0;
          ocomp_q[0]  <= energy_q;
          ocomp_q[1]  <= '0;
          ocomp_q[2]  <= '0;
          energy_q    <= '0;
          i_q         <= '0;
          j_q         <= '0;
          vidx_q      <= '0;
          fin_more_q  <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_FIN_ROW: begin
          // one virial entry a cycle into the output row, cleared behind
          ocomp_q[j_q]  <= vir_q[vidx_q];
          vir_q[vidx_q] <= '0;
          vidx_q        <= vidx_q + 4'd1;
          if (j_q == 2'd2) begin
            j_q         <= '0;
            i_q         <= i_q + 2'd1;
            kind_q      <= KIND_VIRIAL;
            orow_q      <= i_q;
            olast_q     <= (i_q == 2'd2);
            fin_more_q  <= (i_q != 2'd2);
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= fin_more_q ? S_FIN_ROW : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign centre_number_o  = ocid_q;
  assign partner_number_o = onbr_q;
  assign row_select_o     = orow_q;
  assign comp_x_o         = ocomp_q[0];
  assign comp_y_o         = ocomp_q[1];
  assign comp_z_o         = ocomp_q[2];
  assign last_of_run_o    = olast_q;

endmodule

// ===== hdl/eamgk_checker.sv =====
// ----------------------------------------------------------------------------
// eamgk_checker
// Port-level checks for the EAM Gaussian kernel force engine.
// ----------------------------------------------------------------------------
module eamgk_checker import eamgk_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         kind_o,
  input logic [1:0]         row_select_o,
  input logic signed [47:0] comp_x_o,
  input logic signed [47:0] comp_y_o,
  input logic signed [47:0] comp_z_o,
  input logic               last_of_run_o
);

  // one request in flight: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(comp_x_o) && $stable(kind_o))
    else $error("stalled result changed");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> kind_o == KIND_VIRIAL && row_select_o == 2'd2)
    else $error("last marker off the final virial row");

  a_energy_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ENERGY |-> comp_y_o == '0 && comp_z_o == '0 && !last_of_run_o)
    else $error("energy result carries stray fields");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_FINISH |=> !in_ready_o)
    else $error("finish request did not start a run");

endmodule

bind eam_gaussian_kernel_forces_core eamgk_checker u_eamgk_checker (.*);

// ===== bench/tb_eam_gaussian_kernel_forces_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eam_gaussian_kernel_forces_core
// Streams centre, pair and finish requests through the EAM Gaussian kernel
// core under random idling on both sides, predicts every force, energy and
// virial result in fixed point and checks them in order.
// ----------------------------------------------------------------------------
module tb_eam_gaussian_kernel_forces_core import eamgk_pkg::*; ();

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          IDLE_LIMIT = 4000;
  localparam logic [63:0] LIM48      = 64'h7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM32      = 64'h7FFF_FFFF;

  typedef struct {
    logic [1:0]       op;
    logic [15:0]      atom;
    logic [31:0]      sample;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] shift;
  } atom_req_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] cnum;
    logic [15:0] pnum;
    logic [1:0]  row;
    logic [47:0] cx;
    logic [47:0] cy;
    logic [47:0] cz;
    logic        last;
  } kernel_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [15:0]        atom_number_i;
  logic signed [31:0] sample_value_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] shift_x_i, shift_y_i, shift_z_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic [15:0]        centre_number_o;
  logic [15:0]        partner_number_o;
  logic [1:0]         row_select_o;
  logic signed [47:0] comp_x_o, comp_y_o, comp_z_o;
  logic               last_of_run_o;

  eam_gaussian_kernel_forces_core i_dut (.*);

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // predictor state
  logic [63:0] exp_lut [0:256];
  longint      density_centre;
  logic [63:0] inv_width_sq;
  logic [63:0] prefactor;
  longint      energy_acc;
  longint      slope_q;
  logic [15:0] centre_atom;
  longint      centre_pos [3];
  longint      virial_acc [9];

  atom_req_t   pending_reqs [$];
  kernel_res_t expected_results [$];
  atom_req_t   cur_req;
  int          mismatches;
  int          results_seen;
  bit          req_busy, req_taken, res_taken, long_hold_done;
  int          send_gap, recv_stall, idle_cycles;
  bit          send_burst, recv_burst;

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] mul_clip(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint signed_fit(logic [63:0] m, bit neg, logic [63:0] lim);
    if (m == 0) return 0;
    if (neg) begin
      if (m > lim + 1) m = lim + 1;
      return -longint'(m);
    end
    return (m > lim) ? longint'(lim) : longint'(m);
  endfunction

  function automatic longint clamp48(longint x);
    if (x > longint'(LIM48)) return longint'(LIM48);
    if (x < -longint'(LIM48) - 1) return -longint'(LIM48) - 1;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void build_exp_lut();
    logic [63:0] h, term, r;
    longint      acc;
    h    = (64'd1 << 36) / 256;
    term = 64'd1 << 32;
    acc  = longint'(term);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * h) >> 32) / n;
      if (n % 2) acc = acc - longint'(term);
      else       acc = acc + longint'(term);
    end
    r = 64'(acc);
    exp_lut[0] = 64'd1 << 32;
    for (int i = 1; i <= 256; i++) exp_lut[i] = (exp_lut[i-1] * r + (64'd1 << 31)) >> 32;
  endfunction

  // exp(-a), a in Q16, result in Q32
  function automatic logic [63:0] decay_exp(logic [63:0] a);
    logic [63:0] p, idx, frac, lo, hi;
    if (a >= (64'd1 << 20)) return 0;
    p    = a * 256;
    idx  = p >> 20;
    frac = p & ((64'd1 << 20) - 1);
    lo   = exp_lut[idx];
    hi   = exp_lut[idx + 1];
    return lo - (((lo - hi) * frac) >> 20);
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] data);
    case (idx)
      CFG_CENTER: density_centre = longint'($signed(data));
      CFG_INV_W2: inv_width_sq   = 64'(data[30:0]);
      CFG_PREF:   prefactor      = 64'(data[30:0]);
      default: ;
    endcase
  endfunction

  function automatic void predict_kernel(atom_req_t q);
    longint      d, r [3], f [3], v;
    logic [63:0] dm, s, a, val, t, m, sumsq, pm, gm, len, u, fm, vm;
    bit          gneg;
    kernel_res_t res;
    res = '{kind: KIND_FORCE, cnum: 0, pnum: 0, row: 0, cx: 0, cy: 0, cz: 0, last: 0};
    case (q.op)
      OP_START: begin
        d  = longint'($signed(q.sample)) - density_centre;
        dm = magnitude(d);
        if (dm > 64'hFFFF_FFFF) dm = 64'hFFFF_FFFF;
        s   = (dm * dm) >> 16;
        a   = mul_clip(s, inv_width_sq) >> 17;
        val = (prefactor * decay_exp(a)) >> 32;
        energy_acc = clamp48(energy_acc + longint'(val));
        t   = (dm * inv_width_sq) >> 16;
        m   = mul_clip(t, val) >> 16;
        slope_q     = signed_fit(m, d > 0, LIM32);
        centre_atom = q.atom;
        for (int k = 0; k < 3; k++) centre_pos[k] = longint'($signed(q.pos[k]));
      end
      OP_PAIR: begin
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
          r[k] = longint'($signed(q.pos[k])) + longint'($signed(q.shift[k])) - centre_pos[k];
          if (r[k] > longint'(LIM32)) r[k] = longint'(LIM32);
          if (r[k] < -longint'(LIM32) - 1) r[k] = -longint'(LIM32) - 1;
          sumsq = sumsq + magnitude(r[k]) * magnitude(r[k]);
          f[k] = 0;
        end
        pm   = magnitude(longint'($signed(q.sample))) * magnitude(slope_q);
        gneg = ($signed(q.sample) < 0) != (slope_q < 0);
        gm   = pm >> 16;
        if (sumsq != 0) begin
          len = int_sqrt(sumsq);
          for (int k = 0; k < 3; k++) begin
            u    = (magnitude(r[k]) << 16) / len;
            fm   = (u * gm) >> 16;
            f[k] = signed_fit(fm, (r[k] < 0) != gneg, LIM48);
          end
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
              vm = mul_clip(magnitude(f[j]), magnitude(r[i])) >> 16;
              v  = signed_fit(vm, (f[j] < 0) != (r[i] < 0), LIM48);
              virial_acc[i*3+j] = clamp48(virial_acc[i*3+j] - v);
            end
        end
        res.cnum = centre_atom;
        res.pnum = q.atom;
        res.cx   = f[0][47:0];
        res.cy   = f[1][47:0];
        res.cz   = f[2][47:0];
        expected_results.push_back(res);
      end
      OP_FINISH: begin
        res.kind = KIND_ENERGY;
        res.cx   = energy_acc[47:0];
        expected_results.push_back(res);
        for (int row = 0; row < 3; row++) begin
          res.kind = KIND_VIRIAL;
          res.row  = row[1:0];
          res.cx   = virial_acc[row*3][47:0];
          res.cy   = virial_acc[row*3+1][47:0];
          res.cz   = virial_acc[row*3+2][47:0];
          res.last = (row == 2);
          expected_results.push_back(res);
        end
        energy_acc = 0;
        for (int k = 0; k < 9; k++) virial_acc[k] = 0;
      end
      default: ; // unused opcode: no effect
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------- request side ----------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_kernel(cur_req);
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_busy  = 1'b0;
      end
      if (!req_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req  = pending_reqs.pop_front();
          req_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 8);
        end
      end
      in_valid_i     <= req_busy;
      opcode_i       <= cur_req.op;
      atom_number_i  <= cur_req.atom;
      sample_value_i <= cur_req.sample;
      pos_x_i        <= cur_req.pos[0];
      pos_y_i        <= cur_req.pos[1];
      pos_z_i        <= cur_req.pos[2];
      shift_x_i      <= cur_req.shift[0];
      shift_y_i      <= cur_req.shift[1];
      shift_z_i      <= cur_req.shift[2];
    end
  end

  // ---------------- result side ----------------
  always @(posedge clk_i) begin
    kernel_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_taken = 1'b1;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(kind_o), 0);
      end else begin
        want = expected_results.pop_front();
        if (kind_o != want.kind) report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        if (centre_number_o != want.cnum)
          report_mismatch("centre_number", 64'(centre_number_o), 64'(want.cnum));
        if (partner_number_o != want.pnum)
          report_mismatch("partner_number", 64'(partner_number_o), 64'(want.pnum));
        if (row_select_o != want.row)
          report_mismatch("row_select", 64'(row_select_o), 64'(want.row));
        if (comp_x_o != want.cx) report_mismatch("comp_x", 64'(comp_x_o), 64'(want.cx));
        if (comp_y_o != want.cy) report_mismatch("comp_y", 64'(comp_y_o), 64'(want.cy));
        if (comp_z_o != want.cz) report_mismatch("comp_z", 64'(comp_z_o), 64'(want.cz));
        if (last_of_run_o != want.last)
          report_mismatch("last_of_run", 64'(last_of_run_o), 64'(want.last));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
        // one long back-pressure stretch while requests keep coming
        if (!long_hold_done && results_seen >= 40) begin
          long_hold_done = 1'b1;
          recv_stall     = 300;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("** eam_gaussian_kernel_forces_core: FAILED **");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic atom_req_t mk_req(logic [1:0] op, logic [15:0] atom, logic [31:0] sample,
                                       logic [2:0][31:0] pos, logic [2:0][31:0] shift);
    atom_req_t q;
    q.op = op; q.atom = atom; q.sample = sample; q.pos = pos; q.shift = shift;
    return q;
  endfunction

  function automatic logic [31:0] near_zero(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] any_value();
    return ($urandom_range(0, 3) == 0) ? 32'($urandom) : near_zero(1 << 20);
  endfunction

  task automatic drain_and_settle();
    while (pending_reqs.size() > 0 || req_busy || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i); // a trailing start request makes no result
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic random_phase(int n_items);
    logic [2:0][31:0] cpos, p, sh;
    logic [31:0]      centre32;
    int               cnt, pairs;
    centre32 = 32'(density_centre);
    cpos     = '0;
    cnt      = 0;
    while (cnt < n_items) begin
      case ($urandom_range(0, 19))
        0: pending_reqs.push_back(mk_req(OP_UNUSED, 16'($urandom), $urandom,
                                         {$urandom, $urandom, $urandom},
                                         {$urandom, $urandom, $urandom}));
        1, 2: begin
          pending_reqs.push_back(mk_req(OP_FINISH, 16'($urandom), any_value(),
                                        {any_value(), any_value(), any_value()}, '0));
          cnt++;
        end
        3: begin // stray pair with unrelated geometry
          pending_reqs.push_back(mk_req(OP_PAIR, 16'($urandom), $urandom,
                                        {$urandom, $urandom, $urandom},
                                        {$urandom, $urandom, $urandom}));
          cnt++;
        end
        default: begin
          cpos = {any_value(), any_value(), any_value()};
          pending_reqs.push_back(mk_req(OP_START, 16'($urandom),
                                        ($urandom_range(0, 4) == 0) ? $urandom
                                          : centre32 + near_zero(1 << 18),
                                        cpos, {$urandom, $urandom, $urandom}));
          cnt++;
          pairs = $urandom_range(1, 6);
          for (int i = 0; i < pairs; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              p  = cpos; // coincident neighbour
              sh = '0;
            end else begin
              for (int k = 0; k < 3; k++) begin
                p[k]  = cpos[k] + near_zero(1 << 19);
                sh[k] = ($urandom_range(0, 2) == 0) ? near_zero(1 << 20) : 32'd0;
              end
              if ($urandom_range(0, 7) == 0) p[$urandom_range(0, 2)] = $urandom;
            end
            pending_reqs.push_back(mk_req(OP_PAIR, 16'($urandom),
                                          ($urandom_range(0, 3) == 0) ? $urandom
                                            : near_zero(1 << 18), p, sh));
            cnt++;
          end
        end
      endcase
    end
    pending_reqs.push_back(mk_req(OP_FINISH, 16'd0, 32'd0, '0, '0));
    drain_and_settle();
  endtask

  initial begin
    logic [31:0] one;
    one = 32'h0001_0000;
    build_exp_lut();
    density_centre = 0;
    inv_width_sq   = 64'h1_0000;
    prefactor      = 64'h1_0000;
    energy_acc     = 0;
    slope_q        = 0;
    centre_atom    = 0;
    for (int k = 0; k < 3; k++) centre_pos[k] = 0;
    for (int k = 0; k < 9; k++) virial_acc[k] = 0;
    mismatches = 0; results_seen = 0; idle_cycles = 0;
    req_busy = 0; req_taken = 0; res_taken = 0; long_hold_done = 0;
    send_gap = 0; recv_stall = 0; send_burst = 0; recv_burst = 0;
    cur_req = mk_req(OP_START, 0, 0, '0, '0);
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = CFG_CENTER; cfg_data_i = '0;
    in_valid_i = 1'b0; opcode_i = OP_START; atom_number_i = '0; sample_value_i = '0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    shift_x_i = '0; shift_y_i = '0; shift_z_i = '0;
    out_ready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset defaults
    pending_reqs.push_back(mk_req(OP_FINISH, 16'hFFFF, 32'd0, '0, '0));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h1234, one, {one, 32'd0, 32'd0}, '0));
    pending_reqs.push_back(mk_req(OP_START, 16'hFFFF, 32'd0, {one, one, one}, '0));
    pending_reqs.push_back(mk_req(OP_START, 16'h0000, one, '0, '0));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'hFFFF, 32'h7FFF_FFFF, {one, 32'd0, 32'd0}, '0));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h0001, 32'h8000_0000, '0, '0));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h0002, 32'hFFFF_0000,
                                  {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                                  {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h0003, one, {one, one, 32'hFFFF_0000},
                                  {32'hFFFF_0000, 32'd0, one}));
    pending_reqs.push_back(mk_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
    pending_reqs.push_back(mk_req(OP_START, 16'h00AA, 32'h7FFF_FFFF,
                                  {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '1));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h0055, 32'h7FFF_FFFF,
                                  {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                                  {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}));
    pending_reqs.push_back(mk_req(OP_START, 16'h0F0F, 32'h8000_0000, '0, '0));
    pending_reqs.push_back(mk_req(OP_START, 16'h7777, 32'h0000_8000, '0, '0));
    pending_reqs.push_back(mk_req(OP_PAIR, 16'h8888, 32'h8000_0000,
                                  {32'h8000_0000, one, 32'd0}, '0));
    pending_reqs.push_back(mk_req(OP_FINISH, 16'd0, 32'd0, '0, '0));
    drain_and_settle();

    random_phase(75);
    write_reg(CFG_CENTER, 32'h7FFF_FFFF);
    write_reg(CFG_INV_W2, 32'h7FFF_FFFF);
    write_reg(CFG_PREF,   32'h7FFF_FFFF);
    random_phase(70);
    write_reg(CFG_CENTER, 32'h8000_0000);
    write_reg(CFG_INV_W2, 32'h0000_0000);
    write_reg(CFG_PREF,   32'h0000_0000);
    random_phase(60);
    write_reg(CFG_CENTER, 32'h0002_0000);
    write_reg(CFG_INV_W2, 32'h8000_4000); // top bit is outside the register
    write_reg(CFG_PREF,   32'h0010_0000);
    random_phase(75);
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CFG_CENTER, near_zero(1 << 20));
      write_reg(CFG_INV_W2, $urandom_range(0, 32'h0008_0000));
      write_reg(CFG_PREF,   $urandom);
      random_phase(75);
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** eam_gaussian_kernel_forces_core: PASSED **");
    end else begin
      $display("** eam_gaussian_kernel_forces_core: FAILED **");
    end
    $finish;
  end

endmodule
